### src/long_frame_byte_receiver_defines.svh
// ----------------------------------------------------------------------------
// long_frame_byte_receiver_defines
// assertion macros used by the deframer module
// ----------------------------------------------------------------------------
`ifndef LONG_FRAME_BYTE_RECEIVER_DEFINES_SVH
`define LONG_FRAME_BYTE_RECEIVER_DEFINES_SVH

// consequent checked in the cycle after the antecedent, uses clk and rst_n in scope
`define LFBR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequent checked in the same cycle as the antecedent
`define LFBR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### src/lfbr_pkg.sv
// ----------------------------------------------------------------------------
// lfbr_pkg
// shared constants and types of the long frame byte receiver
// ----------------------------------------------------------------------------
package lfbr_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int OUT_COUNT_WIDTH = 32;

    localparam logic [7:0] START_BYTE = 8'h68;
    localparam logic [7:0] END_BYTE   = 8'h16;
    localparam logic [7:0] CA_BYTES   = 8'd2;

    // receive phases
    localparam logic [3:0] PH_WAIT   = 4'd0;
    localparam logic [3:0] PH_LEN    = 4'd1;
    localparam logic [3:0] PH_VERIFY = 4'd2;
    localparam logic [3:0] PH_START2 = 4'd3;
    localparam logic [3:0] PH_CTRL   = 4'd4;
    localparam logic [3:0] PH_ADDR   = 4'd5;
    localparam logic [3:0] PH_DATA   = 4'd6;
    localparam logic [3:0] PH_SUM    = 4'd7;
    localparam logic [3:0] PH_END    = 4'd8;

    // byte kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_CTRL = 2'd1;
    localparam logic [1:0] KIND_ADDR = 2'd2;
    localparam logic [1:0] KIND_DATA = 2'd3;

    // frame events
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_GOOD     = 3'd1;
    localparam logic [2:0] EV_HEADER   = 3'd2;
    localparam logic [2:0] EV_CHECKSUM = 3'd3;
    localparam logic [2:0] EV_END      = 3'd4;

    typedef struct packed {
        logic [7:0]                 field_byte;
        logic [1:0]                 byte_kind;
        logic [2:0]                 frame_event;
        logic [OUT_COUNT_WIDTH-1:0] good_frames;
        logic [OUT_COUNT_WIDTH-1:0] header_errors;
    } lfbr_result_t;

    // low bits of a counter, zero extended when the counter is narrower
    function automatic logic [OUT_COUNT_WIDTH-1:0] count_to_out(
        input logic [COUNT_WIDTH-1:0] c
    );
        logic [COUNT_WIDTH+OUT_COUNT_WIDTH-1:0] w;
        w = {{OUT_COUNT_WIDTH{1'b0}}, c};
        return w[OUT_COUNT_WIDTH-1:0];
    endfunction

endpackage

### src/long_frame_byte_receiver.sv
// ----------------------------------------------------------------------------
// long_frame_byte_receiver
// deframes 0x68 L L 0x68 C A data CS 0x16 frames from a byte stream
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_ready  | rx_byte
//  output  | out_valid / out_ready| field_byte, byte_kind, frame_event,
//          |                      | good_frames, header_errors
//
//  one byte a cycle sustained while out_ready holds; a byte passes an input
//  register and then the frame state update into the result register
//  every accepted byte gives exactly one result request
//  rst_n clears the frame phase, checksum and both counters at once
//  a stalled output holds its result while the input register keeps taking
//  bytes until it fills; nothing is dropped
//
module long_frame_byte_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  field_byte,
    output logic [1:0]  byte_kind,
    output logic [2:0]  frame_event,
    output logic [lfbr_pkg::OUT_COUNT_WIDTH-1:0] good_frames,
    output logic [lfbr_pkg::OUT_COUNT_WIDTH-1:0] header_errors
);
    import lfbr_pkg::*;

    // input register
    logic         s1_valid_reg;
    logic [7:0]   s1_byte_reg;
    // result register
    logic         s2_valid_reg;
    lfbr_result_t s2_result_reg;
    lfbr_result_t step_result;
    logic         adv;

    // byte moves into the result register when that register is free or drains
    assign adv      = s1_valid_reg && (!s2_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= rx_byte;
        end
        if (adv)
        begin
            s2_result_reg <= step_result;
        end
    end

    // frame state lives in the deframer and moves only on an advance
    lfbr_deframer u_deframer (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .rx_byte (s1_byte_reg),
        .result  (step_result)
    );

    assign out_valid     = s2_valid_reg;
    assign field_byte    = s2_result_reg.field_byte;
    assign byte_kind     = s2_result_reg.byte_kind;
    assign frame_event   = s2_result_reg.frame_event;
    assign good_frames   = s2_result_reg.good_frames;
    assign header_errors = s2_result_reg.header_errors;

endmodule

### src/lfbr_deframer.sv
// ----------------------------------------------------------------------------
// lfbr_deframer
// frame state, checksum and counters, one byte per advance
// ----------------------------------------------------------------------------
`include "long_frame_byte_receiver_defines.svh"

module lfbr_deframer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic [7:0]           rx_byte,
    output lfbr_pkg::lfbr_result_t result
);
    import lfbr_pkg::*;

    logic [3:0]             phase_reg, phase_next;
    logic [7:0]             exp_len_reg, exp_len_next;
    logic [7:0]             taken_reg, taken_next;
    logic [7:0]             sum_reg, sum_next;
    logic [COUNT_WIDTH-1:0] good_count_reg, good_count_next;
    logic [COUNT_WIDTH-1:0] error_count_reg, error_count_next;
    logic [1:0]             kind;
    logic [2:0]             ev;
    logic [3:0]             restart_phase;
    logic [7:0]             taken_inc;

    // byte reexamined as a possible start byte
    assign restart_phase = (rx_byte == START_BYTE) ? PH_LEN : PH_WAIT;
    assign taken_inc     = taken_reg + 8'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        exp_len_next     = exp_len_reg;
        taken_next       = taken_reg;
        sum_next         = sum_reg;
        good_count_next  = good_count_reg;
        error_count_next = error_count_reg;
        kind             = KIND_NONE;
        ev               = EV_NONE;
        case (phase_reg)
            PH_LEN:
            begin
                exp_len_next = rx_byte;
                phase_next   = PH_VERIFY;
            end
            PH_VERIFY:
            begin
                if (rx_byte == exp_len_reg)
                begin
                    phase_next = PH_START2;
                end
                else
                begin
                    error_count_next = error_count_reg + COUNT_WIDTH'(1);
                    ev               = EV_HEADER;
                    phase_next       = restart_phase;
                end
            end
            PH_START2:
            begin
                if (rx_byte == START_BYTE)
                begin
                    phase_next = PH_CTRL;
                end
                else
                begin
                    error_count_next = error_count_reg + COUNT_WIDTH'(1);
                    ev               = EV_HEADER;
                    phase_next       = restart_phase;
                end
            end
            PH_CTRL:
            begin
                sum_next   = rx_byte;
                taken_next = 8'd1;
                kind       = KIND_CTRL;
                phase_next = PH_ADDR;
            end
            PH_ADDR:
            begin
                sum_next   = sum_reg + rx_byte;
                taken_next = 8'd2;
                kind       = KIND_ADDR;
                phase_next = (exp_len_reg > CA_BYTES) ? PH_DATA : PH_SUM;
            end
            PH_DATA:
            begin
                sum_next   = sum_reg + rx_byte;
                taken_next = taken_inc;
                kind       = KIND_DATA;
                if (taken_inc >= exp_len_reg)
                begin
                    phase_next = PH_SUM;
                end
            end
            PH_SUM:
            begin
                if (rx_byte == sum_reg)
                begin
                    phase_next = PH_END;
                end
                else
                begin
                    ev         = EV_CHECKSUM;
                    phase_next = restart_phase;
                end
            end
            PH_END:
            begin
                if (rx_byte == END_BYTE)
                begin
                    good_count_next = good_count_reg + COUNT_WIDTH'(1);
                    ev              = EV_GOOD;
                    phase_next      = PH_WAIT;
                end
                else
                begin
                    ev         = EV_END;
                    phase_next = restart_phase;
                end
            end
            default:
            begin
                phase_next = restart_phase;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_WAIT;
            exp_len_reg     <= '0;
            taken_reg       <= '0;
            sum_reg         <= '0;
            good_count_reg  <= '0;
            error_count_reg <= '0;
        end
        else if (adv)
        begin
            phase_reg       <= phase_next;
            exp_len_reg     <= exp_len_next;
            taken_reg       <= taken_next;
            sum_reg         <= sum_next;
            good_count_reg  <= good_count_next;
            error_count_reg <= error_count_next;
        end
    end

    assign result.field_byte    = (kind != KIND_NONE) ? rx_byte : 8'd0;
    assign result.byte_kind     = kind;
    assign result.frame_event   = ev;
    assign result.good_frames   = count_to_out(good_count_next);
    assign result.header_errors = count_to_out(error_count_next);

    `LFBR_ASSERT_NEXT(a_good_counts, adv && (ev == EV_GOOD),
        good_count_reg == $past(good_count_reg) + COUNT_WIDTH'(1),
        "good frame not counted")
    `LFBR_ASSERT_NEXT(a_header_counts, adv && (ev == EV_HEADER),
        error_count_reg == $past(error_count_reg) + COUNT_WIDTH'(1),
        "header error not counted")
    `LFBR_ASSERT_NEXT(a_hold_state, !adv,
        $stable(phase_reg) && $stable(sum_reg) && $stable(taken_reg),
        "frame state moved without a byte")
    `LFBR_ASSERT_NEXT(a_ctrl_then_addr, adv && (phase_reg == PH_CTRL),
        phase_reg == PH_ADDR, "control byte not followed by address phase")

endmodule

### tb/sv/tb_long_frame_byte_receiver.sv
// ----------------------------------------------------------------------------
// tb_long_frame_byte_receiver
// self-checking bench for the variable length frame receiver: a short table
// of hand-picked bytes, then random frames (mostly well formed, some broken,
// some line noise) checked request by request against a cycle-free predictor
// ----------------------------------------------------------------------------
module tb_long_frame_byte_receiver;

    timeunit 1ns;
    timeprecision 1ps;

    import lfbr_pkg::*;

    localparam int RANDOM_ITEMS     = 1620;
    localparam int QUIET_FROM       = 1450;  // no idling on either side beyond this
    localparam int HOLD_OFF_AT      = 500;
    localparam int HOLD_OFF_CYCLES  = 40;
    localparam int DRAIN_CYCLES     = 10;    // margin after the last result is checked
    localparam int LIMIT_CYCLES     = 500000;
    localparam int REPORT_LINES     = 50;

    // ways a random frame gets broken
    localparam int FAULT_NONE   = 0;
    localparam int FAULT_LEN    = 1;
    localparam int FAULT_START2 = 2;
    localparam int FAULT_SUM    = 3;
    localparam int FAULT_END    = 4;
    localparam int FAULT_TRUNC  = 5;

    typedef struct packed {
        logic [7:0]   rx;
        logic         has_want;
        lfbr_result_t want;
    } stim_row_t;

    localparam lfbr_result_t UNCHECKED = '0;

    // directed stimulus; expectations typed in only where obvious, the rest
    // comes from the predictor
    localparam stim_row_t DIRECTED_ROWS [30] = '{
        // idle line byte straight after reset
        '{8'h00,      1'b1, '{8'h00, KIND_NONE, EV_NONE, 32'd0, 32'd0}},
        // length bytes disagree
        '{START_BYTE, 1'b0, UNCHECKED},
        '{8'h05,      1'b0, UNCHECKED},
        '{8'h06,      1'b1, '{8'h00, KIND_NONE, EV_HEADER, 32'd0, 32'd1}},
        // second start byte wrong
        '{START_BYTE, 1'b0, UNCHECKED},
        '{8'h02,      1'b0, UNCHECKED},
        '{8'h02,      1'b0, UNCHECKED},
        '{8'h00,      1'b1, '{8'h00, KIND_NONE, EV_HEADER, 32'd0, 32'd2}},
        // shortest good frame, no user data, checksum wraps to zero
        '{START_BYTE, 1'b0, UNCHECKED},
        '{8'h02,      1'b0, UNCHECKED},
        '{8'h02,      1'b0, UNCHECKED},
        '{START_BYTE, 1'b0, UNCHECKED},
        '{8'hFF,      1'b1, '{8'hFF, KIND_CTRL, EV_NONE, 32'd0, 32'd2}},
        '{8'h01,      1'b0, UNCHECKED},
        '{8'h00,      1'b0, UNCHECKED},
        '{END_BYTE,   1'b1, '{8'h00, KIND_NONE, EV_GOOD, 32'd1, 32'd2}},
        // length one, checksum wrong and the bad byte is a start byte
        '{START_BYTE, 1'b0, UNCHECKED},
        '{8'h01,      1'b0, UNCHECKED},
        '{8'h01,      1'b0, UNCHECKED},
        '{START_BYTE, 1'b0, UNCHECKED},
        '{8'h10,      1'b0, UNCHECKED},
        '{8'h20,      1'b0, UNCHECKED},
        '{START_BYTE, 1'b1, '{8'h00, KIND_NONE, EV_CHECKSUM, 32'd1, 32'd2}},
        // length zero, which follows on from the restart above, bad end byte
        '{8'h00,      1'b0, UNCHECKED},
        '{8'h00,      1'b0, UNCHECKED},
        '{START_BYTE, 1'b0, UNCHECKED},
        '{8'h00,      1'b0, UNCHECKED},
        '{8'h00,      1'b0, UNCHECKED},
        '{8'h00,      1'b0, UNCHECKED},
        '{START_BYTE, 1'b1, '{8'h00, KIND_NONE, EV_END, 32'd1, 32'd2}}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  field_byte;
    logic [1:0]  byte_kind;
    logic [2:0]  frame_event;
    logic [OUT_COUNT_WIDTH-1:0] good_frames;
    logic [OUT_COUNT_WIDTH-1:0] header_errors;

    // predictor state, mirrors the receiver after every accepted byte
    logic [3:0]             rx_state      = PH_WAIT;
    logic [7:0]             frame_len     = 8'h00;
    logic [7:0]             body_count    = 8'h00;
    logic [7:0]             body_sum      = 8'h00;
    logic [COUNT_WIDTH-1:0] good_total    = '0;
    logic [COUNT_WIDTH-1:0] hdr_err_total = '0;

    lfbr_result_t pending_results [$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  bytes_offered  = 0;
    int  noise_bytes    = 0;
    bit  quiet_tail     = 1'b0;
    bit  hold_off_req   = 1'b0;

    long_frame_byte_receiver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .field_byte    (field_byte),
        .byte_kind     (byte_kind),
        .frame_event   (frame_event),
        .good_frames   (good_frames),
        .header_errors (header_errors)
    );

    always #6 clk = ~clk;

    // watchdog: a hung handshake or a lost result ends here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("long_frame_byte_receiver verification failed");
            $finish;
        end
    end

    // one line per mismatch, capped so a broken build keeps the log readable
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES)
            $display("%0d ns: %s got %0h expected %0h", $time, what, got, want);
    endtask

    // next receiver state and result for one line byte; any failure of the
    // header, checksum or end byte looks at the same byte again as a start
    function automatic lfbr_result_t deframe_byte(input logic [7:0] b);
        lfbr_result_t r;
        logic [1:0]   kind;
        logic [2:0]   ev;
        kind = KIND_NONE;
        ev   = EV_NONE;
        case (rx_state)
            PH_LEN:
            begin
                frame_len = b;
                rx_state  = PH_VERIFY;
            end
            PH_VERIFY:
            begin
                if (b == frame_len)
                    rx_state = PH_START2;
                else
                begin
                    hdr_err_total++;
                    ev       = EV_HEADER;
                    rx_state = (b == START_BYTE) ? PH_LEN : PH_WAIT;
                end
            end
            PH_START2:
            begin
                if (b == START_BYTE)
                    rx_state = PH_CTRL;
                else
                begin
                    hdr_err_total++;
                    ev       = EV_HEADER;
                    rx_state = (b == START_BYTE) ? PH_LEN : PH_WAIT;
                end
            end
            PH_CTRL:
            begin
                body_sum   = b;
                body_count = 8'd1;
                kind       = KIND_CTRL;
                rx_state   = PH_ADDR;
            end
            PH_ADDR:
            begin
                body_sum   = body_sum + b;
                body_count = 8'd2;
                kind       = KIND_ADDR;
                rx_state   = (frame_len > CA_BYTES) ? PH_DATA : PH_SUM;
            end
            PH_DATA:
            begin
                body_sum   = body_sum + b;
                body_count = body_count + 8'd1;
                kind       = KIND_DATA;
                if (body_count >= frame_len)
                    rx_state = PH_SUM;
            end
            PH_SUM:
            begin
                if (b == body_sum)
                    rx_state = PH_END;
                else
                begin
                    ev       = EV_CHECKSUM;
                    rx_state = (b == START_BYTE) ? PH_LEN : PH_WAIT;
                end
            end
            PH_END:
            begin
                if (b == END_BYTE)
                begin
                    good_total++;
                    ev       = EV_GOOD;
                    rx_state = PH_WAIT;
                end
                else
                begin
                    ev       = EV_END;
                    rx_state = (b == START_BYTE) ? PH_LEN : PH_WAIT;
                end
            end
            default:
                rx_state = (b == START_BYTE) ? PH_LEN : PH_WAIT;
        endcase
        r.field_byte    = (kind != KIND_NONE) ? b : 8'h00;
        r.byte_kind     = kind;
        r.frame_event   = ev;
        r.good_frames   = OUT_COUNT_WIDTH'(good_total);
        r.header_errors = OUT_COUNT_WIDTH'(hdr_err_total);
        return r;
    endfunction

    // present one byte, hold it until the request is taken, then queue what
    // the receiver must answer; a typed expectation replaces the predicted one
    task automatic offer_byte(input logic [7:0] b, input logic has_want = 1'b0,
                              input lfbr_result_t want = '0);
        lfbr_result_t predicted;
        if (!quiet_tail && $urandom_range(0, 9) == 0)
        begin
            // sender gap of random length
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predicted = deframe_byte(b);
        pending_results.push_back(has_want ? want : predicted);
        bytes_offered++;
    endtask

    // one frame with random length and content, broken now and then; a
    // broken frame stops at the faulty byte and the next frame follows it
    task automatic send_random_frame(input bit max_len);
        logic [7:0] len;
        logic [7:0] sum;
        logic [7:0] b;
        int         fault;
        int         body_len;
        int         cut;
        if (max_len)
            len = 8'hFF;
        else if ($urandom_range(0, 99) < 3)
            len = 8'($urandom_range(200, 255));
        else
            len = 8'($urandom_range(0, 12));
        fault    = ($urandom_range(0, 99) < 75) ? FAULT_NONE
                                                : $urandom_range(FAULT_LEN, FAULT_TRUNC);
        body_len = (len > CA_BYTES) ? int'(len) : int'(CA_BYTES);
        cut      = (fault == FAULT_TRUNC) ? $urandom_range(0, body_len - 1) : body_len;

        offer_byte(START_BYTE);
        offer_byte(len);
        if (fault == FAULT_LEN)
        begin
            offer_byte(len ^ (8'h01 << $urandom_range(0, 7)));
            return;
        end
        offer_byte(len);
        if (fault == FAULT_START2)
        begin
            b = 8'($urandom);
            if (b == START_BYTE)
                b = ~b;
            offer_byte(b);
            return;
        end
        offer_byte(START_BYTE);

        // control, address and user data
        sum = 8'h00;
        for (int k = 0; k < cut; k++)
        begin
            b   = 8'($urandom);
            sum = sum + b;
            offer_byte(b);
        end
        if (fault == FAULT_TRUNC)
            return;

        if (fault == FAULT_SUM)
        begin
            offer_byte(sum + 8'($urandom_range(1, 255)));
            return;
        end
        offer_byte(sum);

        if (fault == FAULT_END)
        begin
            // a start byte in place of the end byte must open a new frame
            b = ($urandom_range(0, 1) == 0) ? START_BYTE : 8'($urandom);
            if (b == END_BYTE)
                b = ~b;
            offer_byte(b);
        end
        else
            offer_byte(END_BYTE);
    endtask

    // stimulus: reset, directed table, random frames, then drain
    initial
    begin : stimulus
        int frame_no;
        int burst;
        bit hold_off_done;
        frame_no      = 0;
        hold_off_done = 1'b0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        rx_byte  = 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[k])
            offer_byte(DIRECTED_ROWS[k].rx, DIRECTED_ROWS[k].has_want,
                       DIRECTED_ROWS[k].want);

        while (bytes_offered - noise_bytes < RANDOM_ITEMS + 30)
        begin
            if (!hold_off_done && bytes_offered >= HOLD_OFF_AT)
            begin
                hold_off_req  = 1'b1;
                hold_off_done = 1'b1;
            end
            quiet_tail = (bytes_offered - noise_bytes) >= QUIET_FROM;

            // occasional line noise between frames
            if ($urandom_range(0, 99) < 15)
            begin
                burst = $urandom_range(1, 3);
                repeat (burst)
                begin
                    offer_byte(8'($urandom));
                    noise_bytes++;
                end
            end

            // the fourth frame carries the longest length
            send_random_frame(frame_no == 3);
            frame_no++;
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("long_frame_byte_receiver verification clean");
        else
            $display("long_frame_byte_receiver verification failed");
        $finish;
    end

    // result side ready: short random stalls, plus one long hold-off that lets
    // the receiver fill up and push back on the byte input
    initial
    begin : result_side
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // every accepted result request against the oldest expectation
    always @(posedge clk)
    begin : result_check
        lfbr_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending, field_byte",
                                32'(field_byte), 32'h0);
            else
            begin
                want = pending_results.pop_front();
                if (field_byte !== want.field_byte)
                    report_mismatch("field_byte", 32'(field_byte), 32'(want.field_byte));
                if (byte_kind !== want.byte_kind)
                    report_mismatch("byte_kind", 32'(byte_kind), 32'(want.byte_kind));
                if (frame_event !== want.frame_event)
                    report_mismatch("frame_event", 32'(frame_event),
                                    32'(want.frame_event));
                if (good_frames !== want.good_frames)
                    report_mismatch("good_frames", 32'(good_frames),
                                    32'(want.good_frames));
                if (header_errors !== want.header_errors)
                    report_mismatch("header_errors", 32'(header_errors),
                                    32'(want.header_errors));
            end
        end
    end

endmodule

### long_frame_byte_receiver.f
+incdir+src
src/lfbr_pkg.sv
src/lfbr_deframer.sv
src/long_frame_byte_receiver.sv
tb/sv/tb_long_frame_byte_receiver.sv
